// ===== rtl/core/asc_pkg.sv =====
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types, constants and the control program of the scanning converter
// calibration block.
// ----------------------------------------------------------------------------
package asc_pkg;

    // default sizing
    localparam int CHANNELS_DEF  = 8;
    localparam int CODE_BITS_DEF = 24;

    // field widths
    localparam int ACTION_W = 2;
    localparam int CODE_W   = 24;
    localparam int LCH_W    = 3;
    localparam int LOAD_W   = 24;
    localparam int GAIN_W   = 20;
    localparam int VALUE_W  = 32;
    localparam int CTRL_W   = 7;

    // datapath widths
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 20;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    // control program
    localparam int UC_DEPTH = 7;
    localparam int PC_W     = $clog2(UC_DEPTH);

    typedef enum logic [ACTION_W-1:0] {
        ACT_SAMPLE    = 2'd0,
        ACT_LOAD_OFS  = 2'd1,
        ACT_LOAD_GAIN = 2'd2,
        ACT_RESERVED  = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNIPOLAR = 2'd0,
        CFG_NARROW   = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [CODE_W-1:0]        sample_code;
        logic [LCH_W-1:0]         load_channel;
        logic signed [LOAD_W-1:0] load_value;
    } t_asc_in;

    typedef struct packed {
        logic [LCH_W-1:0]          channel;
        logic signed [VALUE_W-1:0] value;
        logic [CTRL_W-1:0]         next_control;
    } t_asc_out;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    // multiplier operand selects
    typedef enum logic {
        MA_CODE,
        MA_ACC
    } t_mul_a;

    typedef enum logic [1:0] {
        MB_FULL_SCALE,
        MB_RANGE,
        MB_GAIN
    } t_mul_b;

    // accumulator operations
    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_RND_CODE,
        ALU_RANGE,
        ALU_SUB_OFS,
        ALU_RND_GAIN
    } t_alu_op;

    // one control word
    typedef struct packed {
        logic            mul_en;
        t_mul_a          a_sel;
        t_mul_b          b_sel;
        t_alu_op         alu_op;
        logic            jmp_narrow;
        logic [PC_W-1:0] jmp_target;
        logic            last;
    } t_ucode;

    // program: code scale, round, optional range scale, offset, gain, round and saturate
    function automatic t_ucode uc_rom(input logic [PC_W-1:0] pc);
        t_ucode uc;
        uc = '{mul_en: 1'b0, a_sel: MA_ACC, b_sel: MB_GAIN, alu_op: ALU_NOP,
               jmp_narrow: 1'b0, jmp_target: '0, last: 1'b0};
        unique case (pc)
            3'd0: begin
                uc.mul_en = 1'b1;
                uc.a_sel  = MA_CODE;
                uc.b_sel  = MB_FULL_SCALE;
            end
            3'd1: begin
                uc.alu_op     = ALU_RND_CODE;
                uc.jmp_narrow = 1'b1;
                uc.jmp_target = 3'd4;
            end
            3'd2: begin
                uc.mul_en = 1'b1;
                uc.a_sel  = MA_ACC;
                uc.b_sel  = MB_RANGE;
            end
            3'd3: begin
                uc.alu_op = ALU_RANGE;
            end
            3'd4: begin
                uc.alu_op = ALU_SUB_OFS;
            end
            3'd5: begin
                uc.mul_en = 1'b1;
                uc.a_sel  = MA_ACC;
                uc.b_sel  = MB_GAIN;
            end
            3'd6: begin
                uc.alu_op = ALU_RND_GAIN;
                uc.last   = 1'b1;
            end
            default: begin
                uc.last = 1'b1;
            end
        endcase
        return uc;
    endfunction

endpackage

// ===== rtl/core/adc_scan_calibrate_top.sv =====
// sample transaction: the control program steps one word per cycle through the
// shared multiplier, skipping the range steps with narrow range; the last step
// waits while an earlier result is unaccepted, and no new input is taken until
// the result is registered; load and reserved transactions give no result
// reset: channel 0, offsets 0, gains one, both range registers 0, no result
// ----------------------------------------------------------------------------
// adc_scan_calibrate_top
// Scanning converter front end: code to voltage scaling with range
// conversion and per-channel offset and gain correction.
// ----------------------------------------------------------------------------
module adc_scan_calibrate_top #(
    parameter int CHANNELS  = asc_pkg::CHANNELS_DEF,
    parameter int CODE_BITS = asc_pkg::CODE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  asc_pkg::t_asc_in                   i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output asc_pkg::t_asc_out                  o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [asc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [asc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import asc_pkg::*;

    localparam int CH_W   = $clog2(CHANNELS);
    localparam int EXT_W  = CH_W + LCH_W + 1;
    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 20'sd65536;

    t_seq_state r_state;
    t_seq_state n_state;
    logic [PC_W-1:0] r_pc;
    logic [CH_W-1:0] r_chan;
    logic [CODE_BITS-1:0] r_code;
    logic r_unipolar;
    logic r_narrow;
    logic r_out_valid;
    t_asc_out r_out;
    logic signed [LOAD_W-1:0] r_ofs [CHANNELS];
    logic signed [GAIN_W-1:0] r_gain [CHANNELS];

    t_ucode w_ucode;
    logic w_in_acc;
    logic w_start;
    logic w_run;
    logic w_out_free;
    logic w_step_en;
    logic w_finish;
    logic w_lch_ok;
    logic [EXT_W-1:0] w_lch_ext;
    logic [CH_W-1:0] w_lch;
    logic [CH_W-1:0] n_chan;
    logic [EXT_W-1:0] w_phys_sum;
    logic [EXT_W-1:0] w_phys;
    logic [EXT_W-1:0] w_chan_ext;
    logic signed [VALUE_W-1:0] w_next_acc;

    // handshake and control word
    assign w_ucode    = uc_rom(r_pc);
    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_start    = w_in_acc & (i_in_data.action == ACT_SAMPLE);
    assign w_out_free = ~r_out_valid | i_out_ready;
    assign w_step_en  = w_run & (~w_ucode.last | w_out_free);
    assign w_finish   = w_step_en & w_ucode.last;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SEQ_IDLE: begin
                if (w_start) begin
                    n_state = SEQ_RUN;
                end
            end
            SEQ_RUN: begin
                if (w_finish) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        unique case (r_state)
            SEQ_IDLE: begin
                o_in_ready = 1'b1;
                w_run      = 1'b0;
            end
            SEQ_RUN: begin
                o_in_ready = 1'b0;
                w_run      = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
                w_run      = 1'b0;
            end
        endcase
    end

    // step counter with conditional jump
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_pc <= '0;
            end else if (w_step_en) begin
                if (w_ucode.jmp_narrow && r_narrow) begin
                    r_pc <= w_ucode.jmp_target;
                end else begin
                    r_pc <= r_pc + 1'b1;
                end
            end
        end
    end

    // sample code capture
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_code <= i_in_data.sample_code[CODE_BITS-1:0];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unipolar <= 1'b0;
            r_narrow   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_UNIPOLAR: r_unipolar <= i_cfg_data[0];
                CFG_NARROW:   r_narrow   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // calibration table writes
    assign w_lch_ext = EXT_W'(i_in_data.load_channel);
    assign w_lch_ok  = (int'(i_in_data.load_channel) < CHANNELS);
    assign w_lch     = w_lch_ext[CH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_ofs[i]  <= '0;
                r_gain[i] <= GAIN_ONE;
            end
        end else if (w_in_acc && w_lch_ok) begin
            if (i_in_data.action == ACT_LOAD_OFS) begin
                r_ofs[w_lch] <= i_in_data.load_value;
            end else if (i_in_data.action == ACT_LOAD_GAIN) begin
                r_gain[w_lch] <= i_in_data.load_value[GAIN_W-1:0];
            end
        end
    end

    // next channel and its physical mapping
    assign n_chan     = (int'(r_chan) == CHANNELS - 1) ? '0 : r_chan + 1'b1;
    assign w_phys_sum = EXT_W'(n_chan) + EXT_W'(CHANNELS - 2);
    assign w_phys     = (int'(w_phys_sum) >= CHANNELS) ?
                        w_phys_sum - EXT_W'(CHANNELS) : w_phys_sum;
    assign w_chan_ext = EXT_W'(r_chan);

    // result register and channel advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_chan      <= '0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
            r_chan      <= n_chan;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out.channel      <= w_chan_ext[LCH_W-1:0];
            r_out.value        <= w_next_acc;
            r_out.next_control <= {w_phys[2:0], 4'hF};
        end
    end

    // shared arithmetic
    asc_datapath #(
        .CODE_BITS (CODE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_step_en  (w_step_en),
        .i_ucode    (w_ucode),
        .i_unipolar (r_unipolar),
        .i_code     (r_code),
        .i_offset   (r_ofs[r_chan]),
        .i_gain     (r_gain[r_chan]),
        .o_next_acc (w_next_acc)
    );

endmodule

// ===== rtl/core/asc_datapath.sv =====
// ----------------------------------------------------------------------------
// asc_datapath
// Shared multiplier, product register and accumulator driven one control
// word per cycle while the step enable is high.
// ----------------------------------------------------------------------------
module asc_datapath #(
    parameter int CODE_BITS = asc_pkg::CODE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_step_en,
    input  asc_pkg::t_ucode                      i_ucode,
    input  logic                                 i_unipolar,
    input  logic [CODE_BITS-1:0]                 i_code,
    input  logic signed [asc_pkg::LOAD_W-1:0]    i_offset,
    input  logic signed [asc_pkg::GAIN_W-1:0]    i_gain,
    output logic signed [asc_pkg::VALUE_W-1:0]   o_next_acc
);
    import asc_pkg::*;

    localparam logic signed [MUL_B_W-1:0] K_FULL_SCALE = 20'sd256000;
    localparam logic signed [MUL_B_W-1:0] K_RANGE      = 20'sd125;
    localparam logic signed [PROD_W-1:0]  HALF_CODE    = 47'sd1 <<< (CODE_BITS - 1);
    localparam logic signed [PROD_W-1:0]  HALF_GAIN    = 47'sd32768;
    localparam logic signed [PROD_W-1:0]  SAT_MAX      = 47'sd2147483647;
    localparam logic signed [PROD_W-1:0]  SAT_MIN      = -47'sd2147483648;
    localparam logic signed [VALUE_W-1:0] BIP_SHIFT    = 32'sd1000000;

    logic signed [PROD_W-1:0]  r_prod;
    logic signed [VALUE_W-1:0] r_acc;

    logic signed [MUL_A_W-1:0] w_a;
    logic signed [MUL_B_W-1:0] w_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_rnd_code;
    logic signed [PROD_W-1:0]  w_uni;
    logic signed [PROD_W-1:0]  w_bip;
    logic signed [PROD_W-1:0]  w_rnd_gain;
    logic signed [VALUE_W-1:0] n_acc;

    // operand selection
    always_comb begin
        unique case (i_ucode.a_sel)
            MA_CODE: w_a = MUL_A_W'(i_code);
            MA_ACC:  w_a = r_acc[MUL_A_W-1:0];
            default: w_a = r_acc[MUL_A_W-1:0];
        endcase
        unique case (i_ucode.b_sel)
            MB_FULL_SCALE: w_b = K_FULL_SCALE;
            MB_RANGE:      w_b = K_RANGE;
            MB_GAIN:       w_b = i_gain;
            default:       w_b = i_gain;
        endcase
    end

    assign w_prod = w_a * w_b;

    // rounding shifts of the registered product
    assign w_rnd_code = (r_prod + HALF_CODE) >>> CODE_BITS;
    assign w_uni      = (r_prod + 47'sd16) >>> 5;
    assign w_bip      = (r_prod + 47'sd8) >>> 4;
    assign w_rnd_gain = (r_prod + HALF_GAIN) >>> 16;

    // accumulator update
    always_comb begin
        unique case (i_ucode.alu_op)
            ALU_NOP:      n_acc = r_acc;
            ALU_RND_CODE: n_acc = w_rnd_code[VALUE_W-1:0];
            ALU_RANGE: begin
                if (i_unipolar) begin
                    n_acc = w_uni[VALUE_W-1:0];
                end else begin
                    n_acc = w_bip[VALUE_W-1:0] - BIP_SHIFT;
                end
            end
            ALU_SUB_OFS:  n_acc = r_acc - VALUE_W'(i_offset);
            ALU_RND_GAIN: begin
                if (w_rnd_gain > SAT_MAX) begin
                    n_acc = SAT_MAX[VALUE_W-1:0];
                end else if (w_rnd_gain < SAT_MIN) begin
                    n_acc = SAT_MIN[VALUE_W-1:0];
                end else begin
                    n_acc = w_rnd_gain[VALUE_W-1:0];
                end
            end
            default:      n_acc = r_acc;
        endcase
    end

    assign o_next_acc = n_acc;

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_step_en) begin
            r_acc <= n_acc;
            if (i_ucode.mul_en) begin
                r_prod <= w_prod;
            end
        end
    end

endmodule

// ===== dv/adc_scan_calibrate_top_tb.sv =====
// ----------------------------------------------------------------------------
// adc_scan_calibrate_top_tb
// Self-checking bench for the scanning converter calibration block. A short
// table of directed transactions covers code extremes, wide gain loads and
// unused actions. Random traffic then runs under every range setting with
// random gaps and stalls on both sides. Each result is checked against an
// in-bench calculation of scaling, offset, gain, rounding and channel order.
// ----------------------------------------------------------------------------
module adc_scan_calibrate_top_tb;

    import asc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PHASE_ITEMS    = 120;
    localparam int PRINT_LIMIT    = 50;
    localparam longint VALUE_MAX  = 2147483647;
    localparam longint VALUE_MIN  = -VALUE_MAX - 1;

    // one directed row: the transaction, and a hand-worked result where it is obvious
    typedef struct packed {
        t_asc_in  item;
        logic     typed;
        t_asc_out result;
    } t_dir_row;

    localparam int DIR_N = 19;
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        // code zero after reset, bipolar: bottom of the range on channel 0
        '{'{ACT_SAMPLE, 24'h000000, 3'd0, 24'sh000000}, 1'b1,
          '{3'd0, -32'sd1000000, 7'd127}},
        // full-scale code: top of the range on channel 1
        '{'{ACT_SAMPLE, 24'hFFFFFF, 3'd0, 24'sh000000}, 1'b1,
          '{3'd1, 32'sd1000000, 7'd15}},
        // unused action code, no result and no channel step
        '{'{ACT_RESERVED, 24'hAAAAAA, 3'd5, 24'sh555555}, 1'b0, '0},
        // most negative offset and largest gain on channel 2
        '{'{ACT_LOAD_OFS, 24'h000000, 3'd2, 24'sh800000}, 1'b0, '0},
        '{'{ACT_LOAD_GAIN, 24'h000000, 3'd2, 24'sh07FFFF}, 1'b0, '0},
        '{'{ACT_SAMPLE, 24'hFFFFFF, 3'd0, 24'sh000000}, 1'b0, '0},
        // wide gain load: upper bits dropped, leaves the most negative gain
        '{'{ACT_LOAD_GAIN, 24'h000000, 3'd3, 24'shF80000}, 1'b0, '0},
        '{'{ACT_LOAD_OFS, 24'h000000, 3'd3, 24'sh7FFFFF}, 1'b0, '0},
        '{'{ACT_SAMPLE, 24'h000000, 3'd0, 24'sh000000}, 1'b0, '0},
        // zero gain forces a zero result on channel 4
        '{'{ACT_LOAD_GAIN, 24'h000000, 3'd4, 24'sh000000}, 1'b0, '0},
        '{'{ACT_SAMPLE, 24'h800000, 3'd0, 24'sh000000}, 1'b1,
          '{3'd4, 32'sd0, 7'd63}},
        // wide gain load that stays positive, offset of minus one
        '{'{ACT_LOAD_GAIN, 24'h000000, 3'd5, 24'shF12345}, 1'b0, '0},
        '{'{ACT_LOAD_OFS, 24'h000000, 3'd5, 24'shFFFFFF}, 1'b0, '0},
        '{'{ACT_SAMPLE, 24'h555555, 3'd0, 24'sh000000}, 1'b0, '0},
        '{'{ACT_RESERVED, 24'hFFFFFF, 3'd7, 24'shFFFFFF}, 1'b0, '0},
        '{'{ACT_SAMPLE, 24'h000001, 3'd0, 24'sh000000}, 1'b0, '0},
        '{'{ACT_SAMPLE, 24'hFFFFFE, 3'd0, 24'sh000000}, 1'b0, '0},
        // channel wraps back to 0
        '{'{ACT_SAMPLE, 24'h7FFFFF, 3'd0, 24'sh000000}, 1'b0, '0},
        '{'{ACT_LOAD_OFS, 24'h000000, 3'd7, 24'sh123456}, 1'b0, '0}
    };

    // dut ports
    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     in_valid    = 1'b0;
    logic     o_in_ready;
    t_asc_in  in_data     = '0;
    logic     o_out_valid;
    logic     out_ready   = 1'b0;
    t_asc_out o_out_data;
    logic     cfg_valid   = 1'b0;
    logic     o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // calibration state as the bench sees it
    logic [LCH_W-1:0]         chan_now;
    logic signed [LOAD_W-1:0] ofs_entry  [CHANNELS_DEF];
    logic signed [GAIN_W-1:0] gain_entry [CHANNELS_DEF];
    logic                     range_uni;
    logic                     range_narrow;

    t_asc_out expected_results [$];

    int  mismatch_count = 0;
    int  result_count   = 0;
    int  sample_count   = 0;
    int  load_count     = 0;
    int  unused_count   = 0;
    int  setting_count  = 0;
    int  stall_left     = 0;
    bit  burst          = 1'b0;

    adc_scan_calibrate_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // clock, period 12
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mostly no gap, sometimes a few cycles, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (burst || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // code to volts, range conversion, offset and gain correction for one sample
    function automatic t_asc_out calibrate(input logic [CODE_W-1:0] code);
        longint   volts;
        longint   prod;
        longint   rounded;
        int       nxt;
        int       phys;
        t_asc_out res;
        volts = longint'((64'(code) * 64'd256000 + 64'd8388608) >> CODE_BITS_DEF);
        if (!range_narrow) begin
            if (range_uni)
                volts = (volts * 125 + 16) >>> 5;
            else
                volts = ((volts * 125 + 8) >>> 4) - 1000000;
        end
        prod    = (volts - longint'(ofs_entry[chan_now])) * longint'(gain_entry[chan_now]);
        rounded = (prod + 32768) >>> 16;
        if (rounded > VALUE_MAX)
            rounded = VALUE_MAX;
        if (rounded < VALUE_MIN)
            rounded = VALUE_MIN;
        nxt  = (int'(chan_now) + 1) % CHANNELS_DEF;
        phys = (nxt + CHANNELS_DEF - 2) % CHANNELS_DEF;
        res.channel      = chan_now;
        res.value        = rounded[VALUE_W-1:0];
        res.next_control = CTRL_W'((phys << 4) | 4'hF);
        return res;
    endfunction

    // update bench state for one accepted transaction and queue the result of a sample
    task automatic apply_transaction(input t_asc_in item, input logic typed,
                                     input t_asc_out typed_res);
        t_asc_out res;
        case (item.action)
            ACT_SAMPLE: begin
                res = calibrate(item.sample_code);
                chan_now = LCH_W'((int'(chan_now) + 1) % CHANNELS_DEF);
                expected_results.push_back(typed ? typed_res : res);
                sample_count++;
            end
            ACT_LOAD_OFS: begin
                if (int'(item.load_channel) < CHANNELS_DEF)
                    ofs_entry[item.load_channel] = item.load_value;
                load_count++;
            end
            ACT_LOAD_GAIN: begin
                if (int'(item.load_channel) < CHANNELS_DEF)
                    gain_entry[item.load_channel] = item.load_value[GAIN_W-1:0];
                load_count++;
            end
            default: begin
                unused_count++;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch: %s got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // one input transaction after a random gap
    task automatic send_item(input t_asc_in item, input logic typed, input t_asc_out typed_res);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        apply_transaction(item, typed, typed_res);
    endtask

    // hold off input until all results are back, then let the pipeline empty
    task automatic drain(input int extra);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == CFG_UNIPOLAR)
            range_uni = val;
        else
            range_narrow = val;
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_asc_in random_item();
        t_asc_in item;
        int      r;
        r = $urandom_range(99);
        if (r < 70)
            item.action = ACT_SAMPLE;
        else if (r < 82)
            item.action = ACT_LOAD_OFS;
        else if (r < 94)
            item.action = ACT_LOAD_GAIN;
        else
            item.action = ACT_RESERVED;
        case ($urandom_range(9))
            0:       item.sample_code = '0;
            1:       item.sample_code = '1;
            default: item.sample_code = CODE_W'($urandom());
        endcase
        case ($urandom_range(9))
            0:       item.load_value = 24'sh800000;
            1:       item.load_value = 24'sh7FFFFF;
            default: item.load_value = LOAD_W'($urandom());
        endcase
        item.load_channel = LCH_W'($urandom_range(CHANNELS_DEF - 1));
        return item;
    endfunction

    // result side: random stalls, compare each transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_asc_out want;
        if (o_out_valid && out_ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending, channel",
                                o_out_data.channel, -1);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.channel !== want.channel)
                    report_mismatch("channel", o_out_data.channel, want.channel);
                if (o_out_data.value !== want.value)
                    report_mismatch("value", o_out_data.value, want.value);
                if (o_out_data.next_control !== want.next_control)
                    report_mismatch("next_control", o_out_data.next_control,
                                    want.next_control);
            end
            stall_left = pick_gap();
        end else if (!o_out_valid && !burst && $urandom_range(15) == 0) begin
            stall_left = $urandom_range(1, 4);
        end
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // watchdog: too long without any transaction on any channel
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog expired with %0d results pending", expected_results.size());
        $display("adc_scan_calibrate_top verification failed");
        $finish;
    end

    // stimulus
    initial begin
        logic uni_set [5];
        logic nar_set [5];
        uni_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        nar_set = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

        chan_now     = '0;
        range_uni    = 1'b0;
        range_narrow = 1'b0;
        for (int c = 0; c < CHANNELS_DEF; c++) begin
            ofs_entry[c]  = '0;
            gain_entry[c] = GAIN_W'(65536);
        end

        // reset
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at the reset setting
        setting_count++;
        for (int i = 0; i < DIR_N; i++)
            send_item(DIR_ROWS[i].item, DIR_ROWS[i].typed, DIR_ROWS[i].result);

        // random traffic under each range setting
        for (int ph = 0; ph < 5; ph++) begin
            drain(DRAIN_CYCLES);
            write_reg(CFG_UNIPOLAR, uni_set[ph]);
            write_reg(CFG_NARROW, nar_set[ph]);
            setting_count++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                burst = (n >= 40 && n < 70);
                if (n == 90)
                    drain(0);
                send_item(random_item(), 1'b0, '0);
            end
            burst = 1'b0;
        end

        drain(DRAIN_CYCLES);

        $display("ran %0d samples, %0d table loads and %0d unused actions over %0d settings",
                 sample_count, load_count, unused_count, setting_count);
        $display("checked %0d results, %0d mismatches", result_count, mismatch_count);
        if (mismatch_count == 0)
            $display("adc_scan_calibrate_top verification clean");
        else
            $display("adc_scan_calibrate_top verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/asc_pkg.sv
rtl/core/asc_datapath.sv
rtl/core/adc_scan_calibrate_top.sv
dv/adc_scan_calibrate_top_tb.sv
